### rtl/core/quicksort_engine_defines.svh
// assertion macros for the quicksort engine
// used by quicksort_engine.sv; no other dependencies
`ifndef QUICKSORT_ENGINE_DEFINES_SVH
`define QUICKSORT_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS

// clocked check, disabled while reset is asserted
`define QSE_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("quicksort_engine: assertion failed");

// clocked check that also holds during reset
`define QSE_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("quicksort_engine: assertion failed");

`else

`define QSE_ASSERT(label, clk, rst_n, prop)
`define QSE_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

### rtl/core/qse_pkg.sv
// shared types and constants of the quicksort engine
// no dependencies
`timescale 1ns / 1ps

package qse_pkg;

    // key and register port widths
    localparam int KEY_W      = 32;
    localparam int APB_DATA_W = 32;
    localparam int REG_ADDR_W = 3;

    // register index, taken from the word address bit
    localparam logic REG_IDX_DESCENDING = 1'b0;

    // one key slot: a held key or a key in flight between cells
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
    } slot_t;

    // what every cell of the chain does in a cycle
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_SHIFT  = 2'd2
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     descending;
    } cell_ctrl_t;

endpackage

### rtl/core/qse_in_if.sv
// input channel of the quicksort engine: one key per transaction
// depends on qse_pkg
`timescale 1ns / 1ps

interface qse_in_if;
    logic                       valid;
    logic                       ready;
    logic [qse_pkg::KEY_W-1:0]  key_in;
    logic                       last_in;

    modport source (output valid, output key_in, output last_in, input ready);
    modport sink   (input valid, input key_in, input last_in, output ready);
endinterface

### rtl/core/qse_out_if.sv
// output channel of the quicksort engine: one sorted key per transaction
// depends on qse_pkg
`timescale 1ns / 1ps

interface qse_out_if;
    logic                       valid;
    logic                       ready;
    logic [qse_pkg::KEY_W-1:0]  sorted_key;
    logic                       last_out;
    logic                       overflow;

    modport source (output valid, output sorted_key, output last_out, output overflow,
                    input ready);
    modport sink   (input valid, input sorted_key, input last_out, input overflow,
                    output ready);
endinterface

### rtl/core/qse_cell.sv
// one cell of the sorting chain: holds one key, passes the loser of each
// compare to its right neighbor and takes its right neighbor's key on shift-out
// depends on qse_pkg
`timescale 1ns / 1ps

module qse_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  qse_pkg::cell_ctrl_t ctrl,
    input  qse_pkg::slot_t      cand_in,
    input  qse_pkg::slot_t      shift_in,
    output qse_pkg::slot_t      cand_out,
    output qse_pkg::slot_t      held
);

    logic                        held_valid_reg;
    logic                        held_valid_next;
    logic [qse_pkg::KEY_W-1:0]   held_key_reg;
    logic [qse_pkg::KEY_W-1:0]   held_key_next;
    logic                        cand_valid_reg;
    logic                        cand_valid_next;
    logic [qse_pkg::KEY_W-1:0]   cand_key_reg;
    logic [qse_pkg::KEY_W-1:0]   cand_key_next;
    logic                        cand_first;

    // incoming key goes ahead of the held key in the selected order
    assign cand_first = ctrl.descending ? (cand_in.key > held_key_reg)
                                        : (cand_in.key < held_key_reg);

    // on insert keep the earlier key, hand the other one on; on shift take shift_in
    always_comb
    begin
        held_valid_next = held_valid_reg;
        held_key_next   = held_key_reg;
        cand_valid_next = 1'b0;
        cand_key_next   = cand_in.key;
        case (ctrl.op)
            qse_pkg::OP_INSERT:
            begin
                if (cand_in.valid)
                begin
                    if (!held_valid_reg)
                    begin
                        held_valid_next = 1'b1;
                        held_key_next   = cand_in.key;
                    end
                    else if (cand_first)
                    begin
                        held_key_next   = cand_in.key;
                        cand_valid_next = 1'b1;
                        cand_key_next   = held_key_reg;
                    end
                    else
                    begin
                        cand_valid_next = 1'b1;
                    end
                end
            end
            qse_pkg::OP_SHIFT:
            begin
                held_valid_next = shift_in.valid;
                held_key_next   = shift_in.key;
            end
            qse_pkg::OP_HOLD:
            begin
                held_valid_next = held_valid_reg;
            end
            default:
            begin
                held_valid_next = held_valid_reg;
            end
        endcase
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            cand_valid_reg <= 1'b0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
            cand_valid_reg <= cand_valid_next;
        end
    end

    // key payload
    always_ff @(posedge clk)
    begin
        held_key_reg <= held_key_next;
        cand_key_reg <= cand_key_next;
    end

    assign held     = '{valid: held_valid_reg, key: held_key_reg};
    assign cand_out = '{valid: cand_valid_reg, key: cand_key_reg};

endmodule

### rtl/core/quicksort_engine.sv
// quicksort engine top level: chain of sorting cells, load/drain/emit control,
// register port; depends on qse_pkg, qse_in_if, qse_out_if, qse_cell and
// quicksort_engine_defines.svh
//
//  channel  | kind              | moves
//  ---------+-------------------+-----------------------------------------
//  in_ch    | valid/ready sink  | key_in, last_in (one key per transaction)
//  out_ch   | valid/ready source| sorted_key, last_out, overflow
//  apb      | register port     | descending at byte address 0
//
// keys load at one per cycle while the engine is in its load state; each enters
// cell 0 and ripples one cell a cycle; after the final key, the chain drains
// for a span set by the chain length, then emits one sorted key per cycle
// from cell 0 while out_ch.ready is high
// asynchronous reset empties every cell; no input is taken while a set is emitted
// a stalled output holds the whole chain
`timescale 1ns / 1ps
`include "quicksort_engine_defines.svh"

module quicksort_engine
#(
    parameter int MAX_KEYS = 64
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    qse_in_if.sink                               in_ch,
    qse_out_if.source                            out_ch,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [qse_pkg::REG_ADDR_W-1:0]       paddr,
    input  logic [qse_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [qse_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready
);

    localparam int CNT_W = $clog2(MAX_KEYS + 1);

    typedef enum logic [1:0] {
        ST_LOAD  = 2'd0,
        ST_DRAIN = 2'd1,
        ST_EMIT  = 2'd2
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [CNT_W-1:0]   drain_reg;
    logic [CNT_W-1:0]   drain_next;
    logic               dropped_reg;
    logic               dropped_next;
    logic               descending_reg;
    logic               descending_next;

    logic               in_xfer;
    logic               out_xfer;
    logic               store_key;
    logic               cfg_write;

    qse_pkg::cell_ctrl_t ctrl;
    qse_pkg::slot_t      cand [MAX_KEYS+1];
    qse_pkg::slot_t      held [MAX_KEYS];

    // register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[qse_pkg::REG_ADDR_W-1] == qse_pkg::REG_IDX_DESCENDING)
                       ? {{(qse_pkg::APB_DATA_W-1){1'b0}}, descending_reg}
                       : '0;

    always_comb
    begin
        descending_next = descending_reg;
        if (cfg_write && (paddr[qse_pkg::REG_ADDR_W-1] == qse_pkg::REG_IDX_DESCENDING))
        begin
            descending_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            descending_reg <= 1'b0;
        end
        else
        begin
            descending_reg <= descending_next;
        end
    end

    // handshakes
    assign in_ch.ready = (state_reg == ST_LOAD);
    assign in_xfer     = in_ch.valid && in_ch.ready;
    assign out_xfer    = out_ch.valid && out_ch.ready;
    assign store_key   = in_xfer && (count_reg != CNT_W'(MAX_KEYS));

    // load, drain and emit sequencing
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        drain_next   = drain_reg;
        dropped_next = dropped_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_xfer)
                begin
                    if (store_key)
                    begin
                        count_next = CNT_W'(count_reg + 1'b1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (in_ch.last_in)
                    begin
                        state_next = ST_DRAIN;
                        drain_next = CNT_W'(MAX_KEYS);
                    end
                end
            end
            ST_DRAIN:
            begin
                if (drain_reg == '0)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    drain_next = CNT_W'(drain_reg - 1'b1);
                end
            end
            ST_EMIT:
            begin
                if (out_xfer)
                begin
                    count_next = CNT_W'(count_reg - 1'b1);
                    if (count_reg == CNT_W'(1))
                    begin
                        state_next   = ST_LOAD;
                        dropped_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            drain_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            drain_reg   <= drain_next;
            dropped_reg <= dropped_next;
        end
    end

    // chain control
    always_comb
    begin
        ctrl.descending = descending_reg;
        case (state_reg)
            ST_LOAD:  ctrl.op = qse_pkg::OP_INSERT;
            ST_DRAIN: ctrl.op = qse_pkg::OP_INSERT;
            ST_EMIT:  ctrl.op = out_xfer ? qse_pkg::OP_SHIFT : qse_pkg::OP_HOLD;
            default:  ctrl.op = qse_pkg::OP_HOLD;
        endcase
    end

    // new keys enter at the head of the chain
    assign cand[0] = '{valid: store_key, key: in_ch.key_in};

    // row of cells
    for (genvar i = 0; i < MAX_KEYS; i++)
    begin : g_cell
        qse_pkg::slot_t shift_src;

        if (i == MAX_KEYS - 1)
        begin : g_tail
            assign shift_src = '{valid: 1'b0, key: '0};
        end
        else
        begin : g_body
            assign shift_src = held[i+1];
        end

        qse_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .cand_in  (cand[i]),
            .shift_in (shift_src),
            .cand_out (cand[i+1]),
            .held     (held[i])
        );
    end

    // results come from the head cell
    assign out_ch.valid      = (state_reg == ST_EMIT);
    assign out_ch.sorted_key = held[0].key;
    assign out_ch.last_out   = (count_reg == CNT_W'(1));
    assign out_ch.overflow   = dropped_reg;

    // checks
    `QSE_ASSERT(a_no_load_while_emit, clk, rst_n, !(in_ch.ready && out_ch.valid))
    `QSE_ASSERT(a_emit_from_full_cell, clk, rst_n, out_ch.valid |-> held[0].valid)
    `QSE_ASSERT(a_no_key_lost_off_tail, clk, rst_n, !cand[MAX_KEYS].valid)
    `QSE_ASSERT(a_last_starts_drain, clk, rst_n, (in_xfer && in_ch.last_in) |=> !in_ch.ready)
    `QSE_ASSERT(a_last_out_reopens_load, clk, rst_n, (out_xfer && out_ch.last_out) |=> in_ch.ready)

endmodule

### tb/tb_quicksort_engine.sv
// self-checking testbench of the quicksort engine: loads key sets, predicts the
// sorted output and checks every result; depends on qse_pkg, qse_in_if,
// qse_out_if and the quicksort_engine rtl
`timescale 1ns / 1ps

module tb_quicksort_engine;

    localparam int KEY_W        = qse_pkg::KEY_W;
    localparam int APB_DATA_W   = qse_pkg::APB_DATA_W;
    localparam int REG_ADDR_W   = qse_pkg::REG_ADDR_W;

    localparam int MAX_KEYS     = 64;
    localparam int DRAIN_CYCLES = MAX_KEYS + 16;
    localparam int WATCHDOG_MAX = 2000;

    localparam logic [REG_ADDR_W-1:0] DESCENDING_ADDR = {qse_pkg::REG_IDX_DESCENDING, 2'b00};

    // one expected output transaction
    typedef struct {
        logic [KEY_W-1:0] key;
        bit               last;
        bit               ovf;
    } sorted_item_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [REG_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    qse_in_if  in_ch();
    qse_out_if out_ch();

    // predictor state
    logic [KEY_W-1:0] held_keys[$];
    bit               keys_dropped;
    bit               order_descending;
    sorted_item_t     expected_sorted[$];

    int mismatch_count;
    int idle_cycles;
    bit in_idle_on;
    bit out_stall_on;

    quicksort_engine #(.MAX_KEYS(MAX_KEYS)) dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // error reporting
    task automatic report_error(input string what, input logic [31:0] got,
                                input logic [31:0] want);
        $display("ERROR at %0t: %s: got %h, want %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // store one key, and on the final key sort the set into expected results
    function automatic void store_key_and_sort(input logic [KEY_W-1:0] key, input bit last);
        sorted_item_t     item;
        logic [KEY_W-1:0] hold;
        int               j;
        if (held_keys.size() < MAX_KEYS)
            held_keys.push_back(key);
        else
            keys_dropped = 1'b1;
        if (!last)
            return;
        // insertion sort in the configured order
        for (int i = 1; i < held_keys.size(); i++)
        begin
            hold = held_keys[i];
            j = i - 1;
            while (j >= 0 && (order_descending ? (held_keys[j] < hold)
                                               : (held_keys[j] > hold)))
            begin
                held_keys[j + 1] = held_keys[j];
                j--;
            end
            held_keys[j + 1] = hold;
        end
        for (int i = 0; i < held_keys.size(); i++)
        begin
            item.key  = held_keys[i];
            item.last = (i == held_keys.size() - 1);
            item.ovf  = keys_dropped;
            expected_sorted.push_back(item);
        end
        held_keys.delete();
        keys_dropped = 1'b0;
    endfunction

    // key mix: extremes, small values for duplicates, full range
    function automatic logic [KEY_W-1:0] rand_key();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return KEY_W'($urandom_range(0, 7));
            default: return $urandom();
        endcase
    endfunction

    // one apb access: setup cycle, then access cycle until pready
    task automatic apb_access(input bit write, input logic [REG_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // write the sort order and read it back
    task automatic set_order(input bit desc);
        logic [APB_DATA_W-1:0] rdata;
        apb_access(1'b1, DESCENDING_ADDR, APB_DATA_W'(desc), rdata);
        order_descending = desc;
        apb_access(1'b0, DESCENDING_ADDR, '0, rdata);
        if (rdata[0] !== desc)
            report_error("descending readback", rdata, APB_DATA_W'(desc));
    endtask

    // send one key transaction, with an occasional idle burst before it
    task automatic send_key(input logic [KEY_W-1:0] key, input bit last);
        if (in_idle_on && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.key_in  <= key;
        in_ch.last_in <= last;
        do @(posedge clk); while (!in_ch.ready);
        store_key_and_sort(key, last);
    endtask

    task automatic send_set(input int n);
        for (int i = 0; i < n; i++)
            send_key(rand_key(), i == n - 1);
    endtask

    // let every expected result arrive, then give the engine time to settle
    task automatic wait_drain();
        in_ch.valid <= 1'b0;
        while (expected_sorted.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // directed sets
    task automatic test_single_key();
        set_order(1'b0);
        send_key('1, 1'b1);
        wait_drain();
    endtask

    task automatic test_extremes_ascending();
        send_key('1, 1'b0);
        send_key('0, 1'b0);
        send_key(32'h8000_0000, 1'b0);
        send_key(32'h7FFF_FFFF, 1'b0);
        send_key('0, 1'b0);
        send_key(32'h0000_0001, 1'b1);
        wait_drain();
    endtask

    task automatic test_descending();
        set_order(1'b1);
        send_key(32'h0000_0001, 1'b0);
        send_key('1, 1'b0);
        send_key('0, 1'b0);
        send_key(32'hFFFF_FFFE, 1'b0);
        send_key('1, 1'b0);
        send_key(32'h5555_AAAA, 1'b1);
        wait_drain();
    endtask

    // input in reverse of the order in each mode, descending then ascending
    task automatic test_presorted();
        for (int i = 0; i < 5; i++)
            send_key(KEY_W'(i * 32'h3000_0000), i == 4);
        wait_drain();
        set_order(1'b0);
        for (int i = 0; i < 5; i++)
            send_key(KEY_W'((4 - i) * 32'h3000_0000 + 5), i == 4);
        wait_drain();
    endtask

    // random sets, mostly small, with order changes between them
    task automatic test_random_sets();
        int items;
        int n;
        items = 0;
        while (items < 10)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                wait_drain();
                set_order($urandom_range(0, 1));
            end
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8);
            send_set(n);
            items += n;
        end
        wait_drain();
    endtask

    // full store, then one dropped key and a dropped final key
    task automatic test_overflow();
        set_order($urandom_range(0, 1));
        for (int i = 0; i < MAX_KEYS + 2; i++)
            send_key(rand_key(), i == MAX_KEYS + 1);
        wait_drain();
    endtask

    // closing sets back to back with no idling on either side
    task automatic test_back_to_back();
        int items;
        int n;
        in_idle_on   = 1'b0;
        out_stall_on = 1'b0;
        wait_drain();
        set_order(1'b0);
        items = 0;
        while (items < 12)
        begin
            n = $urandom_range(1, 8);
            send_set(n);
            items += n;
        end
    endtask

    // stimulus sequence
    initial
    begin
        mismatch_count   = 0;
        keys_dropped     = 1'b0;
        order_descending = 1'b0;
        in_idle_on       = 1'b1;
        out_stall_on     = 1'b1;
        rst_n         <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        in_ch.valid   <= 1'b0;
        in_ch.key_in  <= '0;
        in_ch.last_in <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_key();
        test_extremes_ascending();
        test_descending();
        test_presorted();
        test_random_sets();
        test_overflow();
        test_back_to_back();

        wait_drain();
        if (expected_sorted.size() != 0)
            report_error("results left over", 32'(expected_sorted.size()), 0);
        if (mismatch_count == 0)
            $display("quicksort_engine: match");
        else
            $display("quicksort_engine: mismatch");
        $finish;
    end

    // output ready with random stall bursts
    initial
    begin
        out_ch.ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
            if (out_stall_on && $urandom_range(0, 1) == 1)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
        end
    end

    // compare each output transaction with the oldest expectation
    always @(posedge clk)
    begin : check_results
        sorted_item_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_sorted.size() == 0)
                report_error("result with nothing expected", out_ch.sorted_key, 0);
            else
            begin
                want = expected_sorted.pop_front();
                if (out_ch.sorted_key !== want.key)
                    report_error("sorted_key", out_ch.sorted_key, want.key);
                if (out_ch.last_out !== want.last)
                    report_error("last_out", 32'(out_ch.last_out), 32'(want.last));
                if (out_ch.overflow !== want.ovf)
                    report_error("overflow", 32'(out_ch.overflow), 32'(want.ovf));
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_MAX)
        begin
            $display("timeout: no transaction for %0d cycles", WATCHDOG_MAX);
            $display("quicksort_engine: mismatch");
            $finish;
        end
    end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/qse_pkg.sv
rtl/core/qse_in_if.sv
rtl/core/qse_out_if.sv
rtl/core/qse_cell.sv
rtl/core/quicksort_engine.sv
tb/tb_quicksort_engine.sv
